### design/jse_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and escape helpers for the JSON string escaper.
// No dependencies.
package jse_pkg;

  localparam int MaxRes = 12;   // most bytes one input item can produce
  localparam int SeqLen = 6;    // longest escape sequence (\u00XX)

  typedef logic [7:0] byte_t;
  typedef byte_t [2:0] digits_t;
  typedef logic [2:0] pcount_t;
  typedef logic [$clog2(MaxRes+1)-1:0] rcount_t;

  typedef struct packed {
    logic [2:0]             len;
    byte_t [SeqLen-1:0]     b;
  } seq_t;

  localparam byte_t ChBsl   = 8'h5C;
  localparam byte_t ChQuote = 8'h22;
  localparam byte_t ChSlash = 8'h2F;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChBs    = 8'h08;
  localparam byte_t ChFf    = 8'h0C;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChCr    = 8'h0D;
  localparam byte_t ChDel   = 8'h7F;
  localparam byte_t ChSpace = 8'h20;
  localparam byte_t ChZero  = 8'h30;
  localparam byte_t ChNine  = 8'h39;
  localparam byte_t ChUpA   = 8'h41;
  localparam byte_t ChUpF   = 8'h46;
  localparam byte_t ChLoA   = 8'h61;
  localparam byte_t ChLoF   = 8'h66;
  localparam byte_t ChN     = 8'h6E;
  localparam byte_t ChB     = 8'h62;
  localparam byte_t ChF     = 8'h66;
  localparam byte_t ChT     = 8'h74;
  localparam byte_t ChR     = 8'h72;
  localparam byte_t ChU     = 8'h75;

  localparam pcount_t PendNone  = 3'd0;
  localparam pcount_t PendBsl   = 3'd1;
  localparam pcount_t PendU     = 3'd2;
  localparam pcount_t PendFull  = 3'd5;

  function automatic logic is_hex(input byte_t c);
    return (c >= ChZero && c <= ChNine) || (c >= ChLoA && c <= ChLoF) ||
           (c >= ChUpA && c <= ChUpF);
  endfunction

  function automatic logic is_std_escape(input byte_t c);
    return c == ChN || c == ChB || c == ChF || c == ChT || c == ChR ||
           c == ChSlash || c == ChBsl || c == ChQuote;
  endfunction

  function automatic byte_t hex_digit(input logic [3:0] nib);
    if (nib < 4'd10)
      return ChZero + {4'd0, nib};
    else
      return ChUpA + {4'd0, nib} - 8'd10;
  endfunction

  // Escape one byte under the normal rules.
  function automatic seq_t plain_seq(input byte_t c);
    seq_t  s;
    byte_t letter;
    s = '0;
    unique case (c)
      ChLf:    letter = ChN;
      ChBs:    letter = ChB;
      ChFf:    letter = ChF;
      ChTab:   letter = ChT;
      ChCr:    letter = ChR;
      ChQuote: letter = ChQuote;
      ChBsl:   letter = ChBsl;
      default: letter = '0;
    endcase
    if (letter != '0) begin
      s.len  = 3'd2;
      s.b[0] = ChBsl;
      s.b[1] = letter;
    end else if (c < ChSpace || c == ChDel) begin
      s.len  = 3'd6;
      s.b[0] = ChBsl;
      s.b[1] = ChU;
      s.b[2] = ChZero;
      s.b[3] = ChZero;
      s.b[4] = hex_digit(c[7:4]);
      s.b[5] = hex_digit(c[3:0]);
    end else begin
      s.len  = 3'd1;
      s.b[0] = c;
    end
    return s;
  endfunction

  // Failed or cut-off lookahead: escaped backslash, then held bytes verbatim.
  function automatic seq_t flush_seq(input pcount_t pc, input digits_t d);
    seq_t s;
    s = '0;
    if (pc != PendNone && pc <= PendFull) begin
      s.b[0] = ChBsl;
      s.b[1] = ChBsl;
      s.b[2] = ChU;
      s.b[3] = d[0];
      s.b[4] = d[1];
      s.b[5] = d[2];
      s.len  = pc + 3'd1;
    end
    return s;
  endfunction

endpackage

### design/jse_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the escaper's input and result streams.
// Depends on jse_pkg.
interface jse_in_if;
  logic              valid;
  logic              ready;
  jse_pkg::byte_t    in_byte;
  logic              is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface jse_out_if;
  logic              valid;
  logic              ready;
  jse_pkg::byte_t    out_byte;
  logic              run_last;
  logic              string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

### design/json_string_escaper_unit.sv
`timescale 1ns / 1ps
// JSON string escaper, top level: one string byte in, escaped bytes out.
// Depends on jse_pkg and the channel interfaces in jse_if.sv.
//
// Each accepted byte is escaped in the cycle of its transfer and its result bytes
// (up to twelve) are parked in a shift buffer that feeds a registered output
// stage one byte per cycle unless the output stalls. Throughput is set by that
// single output byte lane: an item holds the buffer until its last result byte
// is sent and the next is taken as that byte leaves, so plain bytes stream at one
// item per cycle when unstalled. Lookahead bytes held in partial mode yield nothing
// and are taken at one per cycle. Results pass the shift buffer, then the output
// register. The user must write partial_mode through cfg_we / cfg_wdata only while
// idle (the block does not enforce this); it is sampled only on a backslash.
module json_string_escaper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  jse_in_if.sink      in_chan,
  jse_out_if.source   out_chan
);

  logic                  partial_mode;
  jse_pkg::pcount_t      pending_count;
  jse_pkg::digits_t      pending_digits;

  // result buffer for the item in flight
  jse_pkg::byte_t        buf_q [jse_pkg::MaxRes];
  jse_pkg::rcount_t      buf_cnt;
  logic                  buf_end;

  // output register
  logic                  o_valid;
  jse_pkg::byte_t        o_byte;
  logic                  o_run_last;
  logic                  o_string_end;

  logic                  o_load;
  logic                  emit;
  logic                  accept;

  jse_pkg::pcount_t      pending_count_next;
  jse_pkg::digits_t      pending_digits_next;
  jse_pkg::byte_t        buf_next [jse_pkg::MaxRes];
  jse_pkg::rcount_t      buf_cnt_next;

  assign o_load = !o_valid || out_chan.ready;
  assign emit   = (buf_cnt != '0) && o_load;
  assign in_chan.ready = (buf_cnt == '0) ||
                         (emit && buf_cnt == jse_pkg::rcount_t'(1));
  assign accept = in_chan.valid && in_chan.ready;

  // escape logic for the incoming byte
  always_comb begin
    jse_pkg::seq_t    s1;
    jse_pkg::seq_t    s2;
    jse_pkg::seq_t    s3;
    jse_pkg::byte_t   c;
    jse_pkg::rcount_t n;
    logic             do_fresh;

    c  = in_chan.in_byte;
    s1 = '0;
    s2 = '0;
    s3 = '0;
    do_fresh = 1'b0;
    pending_count_next  = pending_count;
    pending_digits_next = pending_digits;

    unique case (pending_count)
      jse_pkg::PendNone: begin
        do_fresh = 1'b1;
      end
      jse_pkg::PendBsl: begin
        if (jse_pkg::is_std_escape(c)) begin
          s1.len  = 3'd2;
          s1.b[0] = jse_pkg::ChBsl;
          s1.b[1] = c;
          pending_count_next = jse_pkg::PendNone;
        end else if (c == jse_pkg::ChU) begin
          pending_count_next = jse_pkg::PendU;
        end else begin
          s1 = jse_pkg::flush_seq(pending_count, pending_digits);
          do_fresh = 1'b1;
        end
      end
      3'd2, 3'd3, 3'd4, 3'd5: begin
        if (jse_pkg::is_hex(c)) begin
          if (pending_count == jse_pkg::PendFull) begin
            s1.len  = 3'd6;
            s1.b[0] = jse_pkg::ChBsl;
            s1.b[1] = jse_pkg::ChU;
            s1.b[2] = pending_digits[0];
            s1.b[3] = pending_digits[1];
            s1.b[4] = pending_digits[2];
            s1.b[5] = c;
            pending_count_next = jse_pkg::PendNone;
          end else begin
            pending_digits_next[2'(pending_count - jse_pkg::PendU)] = c;
            pending_count_next = pending_count + 3'd1;
          end
        end else begin
          s1 = jse_pkg::flush_seq(pending_count, pending_digits);
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    if (do_fresh) begin
      if (c == jse_pkg::ChBsl && partial_mode) begin
        pending_count_next = jse_pkg::PendBsl;
      end else begin
        pending_count_next = jse_pkg::PendNone;
        s2 = jse_pkg::plain_seq(c);
      end
    end

    if (in_chan.is_last) begin
      s3 = jse_pkg::flush_seq(pending_count_next, pending_digits_next);
      pending_count_next = jse_pkg::PendNone;
    end

    for (int i = 0; i < jse_pkg::MaxRes; i++) begin
      buf_next[i] = '0;
    end
    n = '0;
    for (int k = 0; k < jse_pkg::SeqLen; k++) begin
      if (3'(k) < s1.len && n < jse_pkg::rcount_t'(jse_pkg::MaxRes)) begin
        buf_next[n] = s1.b[k];
        n = n + jse_pkg::rcount_t'(1);
      end
    end
    for (int k = 0; k < jse_pkg::SeqLen; k++) begin
      if (3'(k) < s2.len && n < jse_pkg::rcount_t'(jse_pkg::MaxRes)) begin
        buf_next[n] = s2.b[k];
        n = n + jse_pkg::rcount_t'(1);
      end
    end
    for (int k = 0; k < jse_pkg::SeqLen; k++) begin
      if (3'(k) < s3.len && n < jse_pkg::rcount_t'(jse_pkg::MaxRes)) begin
        buf_next[n] = s3.b[k];
        n = n + jse_pkg::rcount_t'(1);
      end
    end
    buf_cnt_next = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_mode <= 1'b0;
    end else if (cfg_we) begin
      partial_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= jse_pkg::PendNone;
      buf_cnt       <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      buf_cnt       <= buf_cnt_next;
    end else if (emit) begin
      buf_cnt       <= buf_cnt - jse_pkg::rcount_t'(1);
    end
  end

  // payload: held digits and the result buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      pending_digits <= pending_digits_next;
      buf_end        <= in_chan.is_last;
      for (int i = 0; i < jse_pkg::MaxRes; i++) begin
        buf_q[i] <= buf_next[i];
      end
    end else if (emit) begin
      for (int i = 0; i < jse_pkg::MaxRes - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= (buf_cnt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte       <= buf_q[0];
      o_run_last   <= (buf_cnt == jse_pkg::rcount_t'(1));
      o_string_end <= (buf_cnt == jse_pkg::rcount_t'(1)) && buf_end;
    end
  end

  assign out_chan.valid      = o_valid;
  assign out_chan.out_byte   = o_byte;
  assign out_chan.run_last   = o_run_last;
  assign out_chan.string_end = o_string_end;

endmodule

### design/jse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the JSON string escaper, bound to its top level.
// Depends on jse_pkg and json_string_escaper_unit.
module jse_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_is_last,
  input logic            out_valid,
  input logic            out_ready,
  input jse_pkg::byte_t  out_byte,
  input logic            out_run_last,
  input logic            out_string_end
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] ends_owed;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // strings whose final byte went in but whose end marker has not come out
  always_ff @(posedge clk) begin
    if (rst) begin
      ends_owed <= '0;
    end else begin
      ends_owed <= ends_owed + {1'b0, in_xfer && in_is_last}
                             - {1'b0, out_xfer && out_string_end};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_run_last) && $stable(out_string_end))
    else $error("result changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_string_end |-> out_run_last)
    else $error("string end not on last byte of its item");

  a_end_owed: assert property (@(posedge clk) disable iff (rst)
    out_xfer && out_string_end |-> ends_owed != 2'd0)
    else $error("string end transfer without a final input byte");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_is_last     (in_chan.is_last),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_byte       (out_chan.out_byte),
  .out_run_last   (out_chan.run_last),
  .out_string_end (out_chan.string_end)
);
